// ----- rtl/atan2_minimax_polynomial_assert.svh -----
// assertion macros for the arctangent pipeline
`ifndef ATAN2_MINIMAX_POLYNOMIAL_ASSERT_SVH
`define ATAN2_MINIMAX_POLYNOMIAL_ASSERT_SVH
`ifndef ASSERT_OFF
// concurrent assertion on a given clock and active-low reset
`define ASSERT_CLKRST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// concurrent assertion on the block clock and reset
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLKRST(lbl, clk_i, rst_ni, prop, msg)
`else
`define ASSERT_CLKRST(lbl, clk, rstn, prop, msg)
`define ASSERT_STD(lbl, prop, msg)
`endif
`endif

// ----- rtl/atan2p_pkg.sv -----
// shared constants, coefficient table and types for the arctangent pipeline
package atan2p_pkg;

  // default port geometry
  localparam int CoordWidthDef = 16;
  localparam int AngleFracDef  = 13;

  // internal fixed point: ratio, square and accumulator carry 30 fraction bits
  localparam int IntFrac  = 30;
  localparam int QuoWidth = IntFrac + 1;
  localparam int AccWidth = 32;
  localparam int NumCoef  = 7;

  typedef logic signed [AccWidth-1:0] acc_t;

  // odd minimax polynomial coefficients in q30, highest power first
  localparam acc_t PolyCoef [NumCoef] = '{
    32'sd7744777,
    -32'sd37645046,
    32'sd87698811,
    -32'sd143609290,
    32'sd213208227,
    -32'sd357824448,
    32'sd1073741824
  };

  // reflection constants in q30
  localparam int PiWidth = 34;
  localparam logic signed [PiWidth-1:0] PiQ30     = 34'sd3373259426;
  localparam logic signed [PiWidth-1:0] HalfPiQ30 = 34'sd1686629713;

  // octant information that travels beside the data
  typedef struct packed {
    logic zero;
    logic ybig;
    logic xneg;
    logic yneg;
  } octant_t;

endpackage

// ----- rtl/atan2p_div.sv -----
// pipelined restoring divider: ratio = round(small * 2^30 / big), one bit per stage
`include "atan2_minimax_polynomial_assert.svh"

module atan2p_div #(
  parameter int COORD_WIDTH = atan2p_pkg::CoordWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [COORD_WIDTH-1:0]      big_i,
  input  logic [COORD_WIDTH-1:0]      small_i,
  input  atan2p_pkg::octant_t         oct_i,
  output logic                        valid_o,
  output logic [atan2p_pkg::QuoWidth-1:0] ratio_o,
  output atan2p_pkg::octant_t         oct_o
);
  import atan2p_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int NW = CW + QuoWidth;
  localparam logic [QuoWidth-1:0] RatioOne = {1'b1, {IntFrac{1'b0}}};

  // numerator with the half-divisor rounding term folded in
  logic [NW-1:0] num;
  assign num = {1'b0, small_i, {IntFrac{1'b0}}} + NW'(big_i >> 1);

  logic                vld_q [QuoWidth];
  logic [CW-1:0]       rem_q [QuoWidth];
  logic [CW-1:0]       big_q [QuoWidth];
  logic [QuoWidth-1:0] low_q [QuoWidth];
  logic [QuoWidth-1:0] quo_q [QuoWidth];
  octant_t             oct_q [QuoWidth];

  for (genvar k = 0; k < QuoWidth; k++) begin : g_stage
    logic                vld_in;
    logic [CW-1:0]       rem_in;
    logic [CW-1:0]       big_in;
    logic [QuoWidth-1:0] low_in;
    logic [QuoWidth-1:0] quo_in;
    octant_t             oct_in;
    logic [CW:0]         trial;
    logic                ge;

    // stage input: numerator split at the top, or previous stage
    if (k == 0) begin : g_first
      assign vld_in = valid_i;
      assign rem_in = num[NW-1:QuoWidth];
      assign big_in = big_i;
      assign low_in = num[QuoWidth-1:0];
      assign quo_in = '0;
      assign oct_in = oct_i;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign rem_in = rem_q[k-1];
      assign big_in = big_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign oct_in = oct_q[k-1];
    end

    // trial subtract of one quotient bit
    assign trial = {rem_in, low_in[QuoWidth-1]};
    assign ge    = (trial >= {1'b0, big_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? CW'(trial - {1'b0, big_in}) : trial[CW-1:0];
      big_q[k] <= big_in;
      low_q[k] <= {low_in[QuoWidth-2:0], 1'b0};
      quo_q[k] <= {quo_in[QuoWidth-2:0], ge};
      oct_q[k] <= oct_in;
    end
  end

  assign valid_o = vld_q[QuoWidth-1];
  assign ratio_o = quo_q[QuoWidth-1];
  assign oct_o   = oct_q[QuoWidth-1];

  // the smaller magnitude over the larger never exceeds one
  `ASSERT_STD(a_div_ratio_le_one, valid_o && !oct_o.zero |-> ratio_o <= RatioOne, "ratio above one")

endmodule

// ----- rtl/atan2p_poly.sv -----
// pipelined square and horner evaluation of the odd arctangent polynomial
`include "atan2_minimax_polynomial_assert.svh"

module atan2p_poly (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic [atan2p_pkg::QuoWidth-1:0] ratio_i,
  input  atan2p_pkg::octant_t             oct_i,
  output logic                            valid_o,
  output atan2p_pkg::acc_t                t_o,
  output atan2p_pkg::octant_t             oct_o
);
  import atan2p_pkg::*;

  localparam int ProdWidth = 2 * AccWidth;
  localparam int SqWidth   = 2 * QuoWidth;
  localparam int Steps     = NumCoef;
  localparam logic [SqWidth-1:0] SqHalf = SqWidth'(1) << (IntFrac - 1);
  localparam logic signed [ProdWidth-1:0] ProdHalf = ProdWidth'(1) << (IntFrac - 1);

  // round half up at 30 fraction bits, floor semantics for negatives too
  function automatic acc_t round_q30(logic signed [ProdWidth-1:0] v);
    logic signed [ProdWidth-1:0] w;
    w = (v + ProdHalf) >>> IntFrac;
    return acc_t'(w[AccWidth-1:0]);
  endfunction

  // square of the ratio: multiply stage
  logic                sqv_q;
  octant_t             sqo_q;
  logic [SqWidth-1:0]  sq_q;
  logic [QuoWidth-1:0] sqr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqv_q <= 1'b0;
    end else begin
      sqv_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q  <= ratio_i * ratio_i;
    sqr_q <= ratio_i;
    sqo_q <= oct_i;
  end

  // square of the ratio: rounding stage
  logic                v0_q;
  octant_t             o0_q;
  logic [QuoWidth-1:0] s0_q;
  logic [QuoWidth-1:0] r0_q;
  logic [SqWidth-1:0]  sq_rnd;

  assign sq_rnd = sq_q + SqHalf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= sqv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= sq_rnd[IntFrac+QuoWidth-1:IntFrac];
    r0_q <= sqr_q;
    o0_q <= sqo_q;
  end

  // horner steps, each a multiply stage then a round stage that also adds the next coefficient on all but the last step
  logic                          mv_q   [Steps];
  octant_t                       mo_q   [Steps];
  logic signed [ProdWidth-1:0]   prod_q [Steps];
  logic [QuoWidth-1:0]           ms_q   [Steps-1];
  logic [QuoWidth-1:0]           mr_q   [Steps-1];
  logic                          av_q   [Steps];
  octant_t                       ao_q   [Steps];
  acc_t                          acc_q  [Steps];
  logic [QuoWidth-1:0]           as_q   [Steps-1];
  logic [QuoWidth-1:0]           ar_q   [Steps-1];

  for (genvar j = 0; j < Steps; j++) begin : g_step
    logic                v_in;
    octant_t             o_in;
    acc_t                acc_in;
    logic [QuoWidth-1:0] s_in;
    logic [QuoWidth-1:0] r_in;
    acc_t                op;

    // step input
    if (j == 0) begin : g_first
      assign v_in   = v0_q;
      assign o_in   = o0_q;
      assign acc_in = PolyCoef[0];
      assign s_in   = s0_q;
      assign r_in   = r0_q;
    end else begin : g_next
      assign v_in   = av_q[j-1];
      assign o_in   = ao_q[j-1];
      assign acc_in = acc_q[j-1];
      assign s_in   = as_q[j-1];
      assign r_in   = ar_q[j-1];
    end

    // operand: the square for horner steps, the ratio for the final odd factor
    if (j < Steps - 1) begin : g_op_sq
      assign op = acc_t'({1'b0, s_in});
    end else begin : g_op_r
      assign op = acc_t'({1'b0, r_in});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mv_q[j] <= 1'b0;
        av_q[j] <= 1'b0;
      end else begin
        mv_q[j] <= v_in;
        av_q[j] <= mv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      prod_q[j] <= acc_in * op;
      mo_q[j]   <= o_in;
      ao_q[j]   <= mo_q[j];
    end

    // round and add the next coefficient, or round only on the last step
    if (j < Steps - 1) begin : g_add
      always_ff @(posedge clk_i) begin
        ms_q[j]  <= s_in;
        mr_q[j]  <= r_in;
        as_q[j]  <= ms_q[j];
        ar_q[j]  <= mr_q[j];
        acc_q[j] <= round_q30(prod_q[j]) + PolyCoef[j+1];
      end
    end else begin : g_last
      always_ff @(posedge clk_i) begin
        acc_q[j] <= round_q30(prod_q[j]);
      end
    end
  end

  assign valid_o = av_q[Steps-1];
  assign t_o     = acc_q[Steps-1];
  assign oct_o   = ao_q[Steps-1];

  // arctangent of a ratio in zero..one is never negative
  `ASSERT_STD(a_poly_t_nonneg, valid_o && !oct_o.zero |-> !t_o[AccWidth-1], "negative first-octant angle")

endmodule

// ----- rtl/atan2_minimax_polynomial.sv -----
// Four-quadrant arctangent of a signed (y, x) pair as a fully pipelined datapath.
// One pair is taken on every clock at which start_i is high and busy_o is low; busy_o is
// high only in the first cycle after reset. Every transfer returns exactly one angle,
// marked by done_o for one cycle, in signed Q2.ANGLE_FRAC_BITS radians in -pi..pi
// (zero when both inputs are zero). The receiver cannot stall the block, and results
// come out in input order at the input rate. The pipeline is made of the magnitude
// stage, the restoring divider (one quotient bit per stage, 31 stages), the squaring,
// the seven multiply-and-round steps of the polynomial (two stages each) and the three
// stages of octant reflection and output rounding.
`include "atan2_minimax_polynomial_assert.svh"

module atan2_minimax_polynomial #(
  parameter int COORD_WIDTH     = atan2p_pkg::CoordWidthDef,
  parameter int ANGLE_FRAC_BITS = atan2p_pkg::AngleFracDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic signed [COORD_WIDTH-1:0]     y_in_i,
  input  logic signed [COORD_WIDTH-1:0]     x_in_i,
  output logic                              done_o,
  output logic signed [ANGLE_FRAC_BITS+2:0] angle_o
);
  import atan2p_pkg::*;

  localparam int CW      = COORD_WIDTH;
  localparam int OW      = ANGLE_FRAC_BITS + 3;
  localparam int Sh      = IntFrac - ANGLE_FRAC_BITS;
  localparam int Latency = 1 + QuoWidth + 2 + 2 * NumCoef + 3;
  localparam logic [PiWidth-1:0] RoundHalf = PiWidth'(1) << (Sh - 1);
  localparam logic [PiWidth-1:0] PiRounded = (PiWidth'(PiQ30) + RoundHalf) >> Sh;
  localparam logic signed [OW-1:0] AngleMax = OW'(PiRounded);

  // one cycle of busy after reset, then a transfer on every clock at which start_i is high
  logic busy_q;
  logic accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy_o = busy_q;
  assign accept = start_i && !busy_q;

  // magnitudes, octant flags and ordering of the pair
  logic [CW-1:0] ay;
  logic [CW-1:0] ax;
  logic          ybig;
  octant_t       fr_oct_d;

  assign ay   = y_in_i[CW-1] ? ($unsigned(~y_in_i) + CW'(1)) : $unsigned(y_in_i);
  assign ax   = x_in_i[CW-1] ? ($unsigned(~x_in_i) + CW'(1)) : $unsigned(x_in_i);
  assign ybig = (ay > ax);

  always_comb begin
    fr_oct_d.ybig = ybig;
    fr_oct_d.xneg = x_in_i[CW-1];
    fr_oct_d.yneg = y_in_i[CW-1];
    fr_oct_d.zero = (ay == '0) && (ax == '0);
  end

  logic          fr_valid_q;
  logic [CW-1:0] fr_big_q;
  logic [CW-1:0] fr_small_q;
  octant_t       fr_oct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else begin
      fr_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    fr_big_q   <= ybig ? ay : ax;
    fr_small_q <= ybig ? ax : ay;
    fr_oct_q   <= fr_oct_d;
  end

  // ratio of smaller to larger magnitude
  logic                div_valid;
  logic [QuoWidth-1:0] div_ratio;
  octant_t             div_oct;

  atan2p_div #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid_q),
    .big_i   (fr_big_q),
    .small_i (fr_small_q),
    .oct_i   (fr_oct_q),
    .valid_o (div_valid),
    .ratio_o (div_ratio),
    .oct_o   (div_oct)
  );

  // first-octant angle from the polynomial
  logic    poly_valid;
  acc_t    poly_t;
  octant_t poly_oct;

  atan2p_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid),
    .ratio_i (div_ratio),
    .oct_i   (div_oct),
    .valid_o (poly_valid),
    .t_o     (poly_t),
    .oct_o   (poly_oct)
  );

  // reflect about pi/2 when |y| > |x|
  logic                      b1_valid_q;
  octant_t                   b1_oct_q;
  logic signed [PiWidth-1:0] b1_t_q;
  logic signed [PiWidth-1:0] t_ext;

  assign t_ext = PiWidth'(poly_t);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
    end else begin
      b1_valid_q <= poly_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    b1_t_q   <= poly_oct.ybig ? (HalfPiQ30 - t_ext) : t_ext;
    b1_oct_q <= poly_oct;
  end

  // reflect about pi when x < 0, then clamp at zero
  logic                      b2_valid_q;
  octant_t                   b2_oct_q;
  logic [PiWidth-1:0]        b2_a_q;
  logic signed [PiWidth-1:0] b2_t;

  assign b2_t = b1_oct_q.xneg ? (PiQ30 - b1_t_q) : b1_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b2_valid_q <= 1'b0;
    end else begin
      b2_valid_q <= b1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b2_a_q   <= b2_t[PiWidth-1] ? '0 : $unsigned(b2_t);
    b2_oct_q <= b1_oct_q;
  end

  // round the magnitude to the output grid, then apply the sign of y
  logic [PiWidth-1:0] a_rnd;
  logic [OW-1:0]      a_mag;
  logic [OW-1:0]      angle_d;
  logic               done_q;
  logic [OW-1:0]      angle_q;

  assign a_rnd = b2_a_q + RoundHalf;
  assign a_mag = OW'(a_rnd >> Sh);

  always_comb begin
    if (b2_oct_q.zero) begin
      angle_d = '0;
    end else if (b2_oct_q.yneg) begin
      angle_d = OW'(-a_mag);
    end else begin
      angle_d = a_mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= b2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= angle_d;
  end

  assign done_o  = done_q;
  assign angle_o = $signed(angle_q);

  // every result traces back to an earlier transfer at the input
  `ASSERT_STD(a_done_has_source, done_o |-> $past(accept, Latency), "result without a transfer")
  // the angle stays within plus and minus pi on the output grid
  `ASSERT_STD(a_angle_range, done_o |-> (angle_o <= AngleMax) && (angle_o >= -AngleMax), "angle beyond pi")
  // a zero pair gives a zero angle
  `ASSERT_STD(a_zero_pair, done_o && $past(accept && (y_in_i == '0) && (x_in_i == '0), Latency) |-> angle_o == '0, "zero pair gave nonzero angle")

endmodule
